### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl of the heap queue
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### hw/rtl/bmhq_pkg.sv
// shared types, widths and codes of the binary min-heap queue
// no dependencies
package bmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int ENTRY_W  = KEY_W + HANDLE_W;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;

  localparam int IN_DATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ENTRY_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_USER_W = STAT_W + 1;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ACT_W-1:0]  act_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam act_t ACT_INSERT = 2'd0;
  localparam act_t ACT_DELETE = 2'd1;
  localparam act_t ACT_PEEK   = 2'd2;

  localparam stat_t ST_DONE  = 2'd0;
  localparam stat_t ST_FULL  = 2'd1;
  localparam stat_t ST_EMPTY = 2'd2;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } entry_t;

  typedef struct packed {
    stat_t               status;
    logic                min_valid;
    logic [KEY_W-1:0]    min_key;
    logic [HANDLE_W-1:0] min_handle;
    cnt_t                count;
  } result_t;

endpackage

### hw/rtl/bmhq_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bmhq_ram #(
  parameter int DataW = 8,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [1 << AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/bmhq_ctrl.sv
// sift sequencer of the heap queue with its one shared key comparator
// depends on bmhq_pkg and assert_macros.svh; drives the entry ram ports
`include "assert_macros.svh"

module bmhq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bmhq_pkg::act_t    in_act_i,
  input  bmhq_pkg::entry_t  in_entry_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output bmhq_pkg::result_t res_o,
  output logic              ram_we_o,
  output bmhq_pkg::addr_t   ram_waddr_o,
  output bmhq_pkg::entry_t  ram_wdata_o,
  output bmhq_pkg::addr_t   ram_raddr_o,
  input  bmhq_pkg::entry_t  ram_rdata_i
);

  typedef logic [bmhq_pkg::CNT_W:0] child_t;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP_RD  = 4'd1;
  localparam logic [3:0] S_UP_CMP = 4'd2;
  localparam logic [3:0] S_DEL_RD = 4'd3;
  localparam logic [3:0] S_DEL_LD = 4'd4;
  localparam logic [3:0] S_DN_RDL = 4'd5;
  localparam logic [3:0] S_DN_RDR = 4'd6;
  localparam logic [3:0] S_DN_CMP = 4'd7;
  localparam logic [3:0] S_DN_MV  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]       state_q, state_d;
  bmhq_pkg::cnt_t   cnt_q, cnt_d;
  bmhq_pkg::cnt_t   pos_q, pos_d;
  bmhq_pkg::stat_t  status_q, status_d;
  bmhq_pkg::entry_t cur_q, cur_d;
  bmhq_pkg::entry_t left_q, left_d;
  bmhq_pkg::entry_t pick_q, pick_d;
  bmhq_pkg::cnt_t   pick_pos_q, pick_pos_d;
  logic             has_right_q, has_right_d;
  bmhq_pkg::entry_t root_q;

  bmhq_pkg::cnt_t              parent_idx;
  child_t                      child_idx;
  child_t                      cnt_ext;
  logic [bmhq_pkg::KEY_W-1:0]  cmp_a, cmp_b;
  logic                        cmp_lt;
  logic                        take_right;

  assign parent_idx = pos_q >> 1;
  assign child_idx  = {pos_q, 1'b0};
  assign cnt_ext    = {1'b0, cnt_q};

  // the single key comparator, operands chosen by state
  always_comb begin
    unique case (state_q)
      S_DN_CMP: begin
        cmp_a = ram_rdata_i.key;
        cmp_b = left_q.key;
      end
      S_DN_MV: begin
        cmp_a = pick_q.key;
        cmp_b = cur_q.key;
      end
      default: begin
        cmp_a = cur_q.key;
        cmp_b = ram_rdata_i.key;
      end
    endcase
  end

  assign cmp_lt     = cmp_a < cmp_b;
  assign take_right = has_right_q && cmp_lt;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    status_d    = status_q;
    cur_d       = cur_q;
    left_d      = left_q;
    pick_d      = pick_q;
    pick_pos_d  = pick_pos_q;
    has_right_d = has_right_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = bmhq_pkg::addr_t'(pos_q - bmhq_pkg::cnt_t'(1));
    ram_wdata_o = cur_q;
    ram_raddr_o = bmhq_pkg::addr_t'(parent_idx - bmhq_pkg::cnt_t'(1));

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = bmhq_pkg::ST_DONE;
          cur_d    = in_entry_i;
          state_d  = S_DONE;
          priority if (in_act_i == bmhq_pkg::ACT_INSERT) begin
            if (cnt_q == bmhq_pkg::CAP_CNT) begin
              status_d = bmhq_pkg::ST_FULL;
            end else begin
              cnt_d   = cnt_q + bmhq_pkg::cnt_t'(1);
              pos_d   = cnt_q + bmhq_pkg::cnt_t'(1);
              state_d = S_UP_RD;
            end
          end else if (in_act_i == bmhq_pkg::ACT_DELETE) begin
            if (cnt_q == '0) begin
              status_d = bmhq_pkg::ST_EMPTY;
            end else begin
              cnt_d   = cnt_q - bmhq_pkg::cnt_t'(1);
              state_d = S_DEL_RD;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_UP_RD: begin
        if (pos_q == bmhq_pkg::cnt_t'(1)) begin
          ram_we_o = 1'b1;
          state_d  = S_DONE;
        end else begin
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // parent is in ram_rdata_i
        ram_we_o = 1'b1;
        if (cmp_lt) begin
          ram_wdata_o = ram_rdata_i;
          pos_d       = parent_idx;
          state_d     = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DEL_RD: begin
        // old last slot sits at the address equal to the new count
        ram_raddr_o = bmhq_pkg::addr_t'(cnt_q);
        state_d     = S_DEL_LD;
      end
      S_DEL_LD: begin
        cur_d = ram_rdata_i;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          pos_d   = bmhq_pkg::cnt_t'(1);
          state_d = S_DN_RDL;
        end
      end
      S_DN_RDL: begin
        if (child_idx > cnt_ext) begin
          ram_we_o = 1'b1;
          state_d  = S_DONE;
        end else begin
          ram_raddr_o = bmhq_pkg::addr_t'(child_idx - child_t'(1));
          state_d     = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        left_d      = ram_rdata_i;
        has_right_d = child_idx < cnt_ext;
        ram_raddr_o = bmhq_pkg::addr_t'(child_idx);
        state_d     = S_DN_CMP;
      end
      S_DN_CMP: begin
        pick_d     = take_right ? ram_rdata_i : left_q;
        pick_pos_d = bmhq_pkg::cnt_t'(child_idx) + bmhq_pkg::cnt_t'(take_right);
        state_d    = S_DN_MV;
      end
      S_DN_MV: begin
        ram_we_o = 1'b1;
        if (cmp_lt) begin
          ram_wdata_o = pick_q;
          pos_d       = pick_pos_q;
          state_d     = S_DN_RDL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    status_q    <= status_d;
    cur_q       <= cur_d;
    left_q      <= left_d;
    pick_q      <= pick_d;
    pick_pos_q  <= pick_pos_d;
    has_right_q <= has_right_d;
    // mirror of the root slot
    if (ram_we_o && (ram_waddr_o == '0)) begin
      root_q <= ram_wdata_o;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.status     = status_q;
    res_o.min_valid  = (cnt_q != '0);
    res_o.min_key    = (cnt_q != '0) ? root_q.key : '0;
    res_o.min_handle = (cnt_q != '0) ? root_q.handle : '0;
    res_o.count      = cnt_q;
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= bmhq_pkg::CAP_CNT,
                 "entry count above capacity")
  `ASSERT_NEXT(a_ins_grow, clk_i, rst_ni,
               in_valid_i && in_ready_o && (in_act_i == bmhq_pkg::ACT_INSERT) && (cnt_q != bmhq_pkg::CAP_CNT),
               cnt_q == ($past(cnt_q) + bmhq_pkg::cnt_t'(1)),
               "insert did not grow the count")
  `ASSERT_IMPL(a_wr_in_range, clk_i, rst_ni, ram_we_o,
               bmhq_pkg::cnt_t'(ram_waddr_o) < cnt_q,
               "ram write beyond held entries")
  `ASSERT_IMPL(a_no_wr_idle, clk_i, rst_ni, (state_q == S_IDLE) || (state_q == S_DONE),
               !ram_we_o, "ram written outside a sift")

endmodule

### hw/rtl/binary_min_heap_queue_unit.sv
// top level of the binary min-heap priority queue: stream ports and result register
// depends on bmhq_pkg, bmhq_ram and bmhq_ctrl
//
// channel   dir  tdata                                 tuser
// s_axis    in   [31:0] key_value [47:32] entry_handle  [1:0] action
// m_axis    out  [31:0] min_key [47:32] min_handle      [1:0] status [2] min_valid
//                [54:48] entry_count [55] zero
//
// one request at a time, paced by the single ram read port; an insert moves the
// new entry up to 6 levels up, a delete moves the last entry up to 5 levels down,
// and a peek or a refused request moves nothing
// reset clears the entry count, the sequencer state and the output valid flag; the entry ram is never cleared
// a finished result waits in the output register; the next request is taken
// meanwhile and only its own result stalls until the register frees up
module binary_min_heap_queue_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] key_value, [47:32] entry_handle
  input  logic [bmhq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] action
  input  logic [bmhq_pkg::ACT_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] min_key, [47:32] min_handle, [54:48] entry_count, rest zero
  output logic [bmhq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [1:0] status, [2] min_valid
  output logic [bmhq_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  bmhq_pkg::entry_t  in_entry;
  bmhq_pkg::result_t res;
  logic              res_valid;
  logic              res_ready;

  logic              ram_we;
  bmhq_pkg::addr_t   ram_waddr;
  bmhq_pkg::addr_t   ram_raddr;
  bmhq_pkg::entry_t  ram_wdata;
  bmhq_pkg::entry_t  ram_rdata;

  logic              out_valid_q;
  bmhq_pkg::result_t out_q;

  // unpack the request payload
  assign in_entry.key    = s_axis_tdata[bmhq_pkg::KEY_W-1:0];
  assign in_entry.handle = s_axis_tdata[bmhq_pkg::ENTRY_W-1:bmhq_pkg::KEY_W];

  // the sequencer may hand over a result whenever the output slot is free
  // or is being emptied in this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_act_i    (s_axis_tuser),
    .in_entry_i  (in_entry),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // entry store, one slot per heap position, position p at address p-1
  bmhq_ram #(
    .DataW (bmhq_pkg::ENTRY_W),
    .AddrW (bmhq_pkg::ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = bmhq_pkg::OUT_DATA_W'({out_q.count, out_q.min_handle, out_q.min_key});
  assign m_axis_tuser  = {out_q.min_valid, out_q.status};

endmodule
